// ===== hdl/pbof_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbof_pkg
// Shared types, constants and the arctangent table of the polar bin filter.
// ----------------------------------------------------------------------------
package pbof_pkg;

	localparam int BINS         = 1800;
	localparam int BIN_W        = $clog2(BINS);
	localparam int TURN_BINS    = 1800;
	localparam int TBIN_W       = $clog2(TURN_BINS);
	localparam int ANG_W        = 20;
	localparam int PROD_W       = ANG_W + TBIN_W;
	localparam int CORDIC_STEPS = 19;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 32;
	localparam int RSQ_W        = 24;

	localparam logic [ANG_W-1:0] HALF_TURN   = 20'h80000;
	localparam logic [ANG_W-1:0] THREE_QUART = 20'hC0000;

	typedef enum logic [2:0] {
		REG_RANGE_MIN  = 3'd0,
		REG_RANGE_MAX  = 3'd1,
		REG_GROUND_LOW = 3'd2,
		REG_BAND_SPLIT = 3'd3,
		REG_OBST_HIGH  = 3'd4,
		REG_Y_OFFSET   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_GROUND   = 2'd1,
		KIND_OBSTACLE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CORDIC,
		ST_ADDR,
		ST_MERGE,
		ST_RSP
	} state_t;

	typedef struct packed {
		logic              vld;
		logic              zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [ANG_W-1:0]  z;
	} cordic_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} point_t;

	typedef struct packed {
		logic             obst_vld;
		logic             gnd_vld;
		logic [RSQ_W-1:0] gnd_rsq;
		point_t           gnd_pt;
		logic [RSQ_W-1:0] obst_rsq;
		point_t           obst_pt;
	} entry_t;

	function automatic logic [ANG_W-1:0] atan_turn(input int i);
		logic [ANG_W-1:0] a;
		case (i)
			0:  a = 20'd131072;
			1:  a = 20'd77376;
			2:  a = 20'd40884;
			3:  a = 20'd20753;
			4:  a = 20'd10417;
			5:  a = 20'd5213;
			6:  a = 20'd2607;
			7:  a = 20'd1304;
			8:  a = 20'd652;
			9:  a = 20'd326;
			10: a = 20'd163;
			11: a = 20'd81;
			12: a = 20'd41;
			13: a = 20'd20;
			14: a = 20'd10;
			15: a = 20'd5;
			16: a = 20'd3;
			17: a = 20'd1;
			18: a = 20'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/polar_bin_obstacle_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polar_bin_obstacle_filter
// Bins lidar points by bearing, keeps farthest ground and nearest obstacle
// point per bin, and returns and clears a bin on a read command.
// ----------------------------------------------------------------------------
// Add: busy through load, 19 CORDIC cells, bin multiply, range check with
//   RAM read, and merge write; no read or merge outside the range window.
// Read: busy only while the bin is cleared; result strobe registered as it
//   ends, or at the accepting edge for a bin past the last (busy stays low).
// One item at a time, set by the bin RAM read-modify-write. After reset a
// clearing pass writes every bin with busy high; configuration writes are
// taken throughout. Results cannot be stalled.
module polar_bin_obstacle_filter (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_index,
	input  wire [15:0]        cfg_data,
	input  wire               start,
	output logic              busy,
	input  wire               command,
	input  wire signed [15:0] point_x,
	input  wire signed [15:0] point_y,
	input  wire signed [15:0] point_z,
	input  wire [10:0]        bin_index,
	output logic              done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic [1:0]        point_kind
);
	import pbof_pkg::*;

	// configuration
	logic [11:0]        range_min_q;
	logic [11:0]        range_max_q;
	logic signed [15:0] gnd_low_q;
	logic signed [15:0] split_q;
	logic signed [15:0] obst_high_q;
	logic signed [15:0] y_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= 12'd20;
			range_max_q <= 12'd2000;
			gnd_low_q   <= -16'sd50;
			split_q     <= 16'sd30;
			obst_high_q <= 16'sd180;
			y_off_q     <= 16'sd714;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE_MIN:  range_min_q <= cfg_data[11:0];
				REG_RANGE_MAX:  range_max_q <= cfg_data[11:0];
				REG_GROUND_LOW: gnd_low_q   <= cfg_data;
				REG_BAND_SPLIT: split_q     <= cfg_data;
				REG_OBST_HIGH:  obst_high_q <= cfg_data;
				REG_Y_OFFSET:   y_off_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic [BIN_W-1:0]   clr_q;
	logic [BIN_W-1:0]   bin_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic signed [31:0] xsq_q, ysq_q;
	logic [31:0]        r2_q;
	logic [RSQ_W-1:0]   lo_q, hi_q;
	logic [PROD_W-1:0]  binprod_q;

	cordic_t chain [CORDIC_STEPS+1];
	cordic_t c0_q;

	logic accept, accept_add, accept_rd, rd_in_range;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign accept_add  = accept && !command;
	assign accept_rd   = accept && command;
	assign rd_in_range = (32'(bin_index) < BINS);

	// vector set-up: scale by 10 and 256, subtract the y offset, fold left half-plane onto the right
	logic signed [CW-1:0] sx, sy, cx0, cy0;
	cordic_t              c0_d;

	always_comb begin
		sx   = CW'(point_x);
		sy   = CW'(point_y);
		cx0  = (sx <<< 11) + (sx <<< 9);
		cy0  = ((sy <<< 3) + (sy <<< 1) - CW'(y_off_q)) <<< 8;
		c0_d.vld  = 1'b1;
		c0_d.zero = (cx0 == '0) && (cy0 == '0);
		if (cx0[CW-1]) begin
			c0_d.x = -cx0;
			c0_d.y = -cy0;
			c0_d.z = HALF_TURN;
		end else begin
			c0_d.x = cx0;
			c0_d.y = cy0;
			c0_d.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q <= '0;
		end else if (accept_add) begin
			c0_q <= c0_d;
		end else begin
			c0_q.vld <= 1'b0;
		end
	end

	assign chain[0] = c0_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		pbof_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP_W'(i)),
			.atan   (atan_turn(i)),
			.d_in   (chain[i]),
			.d_out  (chain[i+1])
		);
	end

	cordic_t          c_end;
	logic [ANG_W-1:0] ang, tgt;
	logic [TBIN_W-1:0] bin_raw;
	logic [BIN_W-1:0]  bin_clamp;
	logic              in_range;

	always_comb begin
		c_end     = chain[CORDIC_STEPS];
		ang       = c_end.zero ? '0 : c_end.z;
		tgt       = THREE_QUART - ang;
		bin_raw   = binprod_q[PROD_W-1:ANG_W];
		bin_clamp = (32'(bin_raw) > BINS - 1) ? BIN_W'(BINS - 1) : BIN_W'(bin_raw);
		in_range  = !((r2_q < 32'(lo_q)) || (r2_q > 32'(hi_q)));
	end

	// bin RAM
	logic              rd_en, wr_en;
	logic [BIN_W-1:0]  rd_addr, wr_addr;
	entry_t            wr_ent, rd_ent, merged;
	logic [$bits(entry_t)-1:0] rd_raw;

	pbof_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (BINS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign rd_ent = entry_t'(rd_raw);

	logic             in_gnd, in_obst;
	logic [RSQ_W-1:0] r2n;

	always_comb begin
		r2n     = r2_q[RSQ_W-1:0];
		in_gnd  = (pz_q > gnd_low_q) && (pz_q < split_q);
		in_obst = (pz_q >= split_q) && (pz_q < obst_high_q);
		merged  = rd_ent;
		if (in_gnd) begin
			if (!rd_ent.gnd_vld || (r2n > rd_ent.gnd_rsq)) begin
				merged.gnd_vld = 1'b1;
				merged.gnd_rsq = r2n;
				merged.gnd_pt  = '{x: px_q, y: py_q, z: pz_q};
			end
		end else if (in_obst) begin
			if (!rd_ent.obst_vld || (r2n < rd_ent.obst_rsq)) begin
				merged.obst_vld = 1'b1;
				merged.obst_rsq = r2n;
				merged.obst_pt  = '{x: px_q, y: py_q, z: pz_q};
			end
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = bin_q;
		wr_en   = 1'b0;
		wr_addr = bin_q;
		wr_ent  = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == BIN_W'(BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept_add) begin
					state_d = ST_CORDIC;
				end else if (accept_rd && rd_in_range) begin
					rd_en   = 1'b1;
					rd_addr = BIN_W'(bin_index);
					state_d = ST_RSP;
				end
			end
			ST_CORDIC: begin
				if (c_end.vld) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				if (in_range) begin
					rd_en   = 1'b1;
					rd_addr = bin_clamp;
					state_d = ST_MERGE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_ent  = merged;
				state_d = ST_IDLE;
			end
			ST_RSP: begin
				wr_en   = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			done <= (accept_rd && !rd_in_range) || (state_q == ST_RSP);
		end
	end

	kind_t kind;

	always_comb begin
		case ({rd_ent.obst_vld, rd_ent.gnd_vld})
			2'b01: kind = KIND_GROUND;
			2'b10: kind = KIND_OBSTACLE;
			2'b11: kind = (rd_ent.gnd_rsq < rd_ent.obst_rsq) ? KIND_GROUND : KIND_OBSTACLE;
			default: kind = KIND_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		lo_q  <= RSQ_W'(range_min_q * range_min_q);
		hi_q  <= RSQ_W'(range_max_q * range_max_q);
		r2_q  <= $unsigned(xsq_q) + $unsigned(ysq_q);
		if (accept) begin
			px_q  <= point_x;
			py_q  <= point_y;
			pz_q  <= point_z;
			xsq_q <= point_x * point_x;
			ysq_q <= point_y * point_y;
			bin_q <= BIN_W'(bin_index);
		end
		if (state_q == ST_CORDIC && c_end.vld) begin
			binprod_q <= PROD_W'(tgt) * PROD_W'(TURN_BINS);
		end
		if (state_q == ST_ADDR) begin
			bin_q <= bin_clamp;
		end
		if (accept_rd && !rd_in_range) begin
			out_x      <= '0;
			out_y      <= '0;
			out_z      <= '0;
			point_kind <= KIND_NONE;
		end else if (state_q == ST_RSP) begin
			point_kind <= kind;
			case (kind)
				KIND_GROUND: begin
					out_x <= rd_ent.gnd_pt.x;
					out_y <= rd_ent.gnd_pt.y;
					out_z <= rd_ent.gnd_pt.z;
				end
				KIND_OBSTACLE: begin
					out_x <= rd_ent.obst_pt.x;
					out_y <= rd_ent.obst_pt.y;
					out_z <= rd_ent.obst_pt.z;
				end
				default: begin
					out_x <= '0;
					out_y <= '0;
					out_z <= '0;
				end
			endcase
		end
	end

	logic [CORDIC_STEPS:0] vld_vec;

	always_comb begin
		for (int i = 0; i <= CORDIC_STEPS; i++) begin
			vld_vec[i] = chain[i].vld;
		end
	end

`ifndef NO_ASSERTIONS
	// only one item lives in the cell row at a time
	a_one_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec))
		else $error("more than one item in CORDIC chain");

	a_chain_end_state: assert property (@(posedge clk) disable iff (!arst_n)
		c_end.vld |-> (state_q == ST_CORDIC))
		else $error("CORDIC result outside CORDIC state");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RSP || (accept_rd && !rd_in_range)))
		else $error("result strobe without a read");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("bin RAM written while idle");
`endif
endmodule
`default_nettype wire

// ===== hdl/pbof_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbof_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pbof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/pbof_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbof_cordic_cell
// One vectoring CORDIC micro-rotation, registered, handing on to the next cell.
// ----------------------------------------------------------------------------
module pbof_cordic_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [pbof_pkg::STEP_W-1:0]   step,
	input  wire [pbof_pkg::ANG_W-1:0]    atan,
	input  pbof_pkg::cordic_t            d_in,
	output pbof_pkg::cordic_t            d_out
);
	import pbof_pkg::*;

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_t              nxt;

	always_comb begin
		dx  = d_in.y >>> step;
		dy  = d_in.x >>> step;
		nxt = d_in;
		if (!d_in.y[CW-1]) begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + atan;
		end else begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/polar_bin_obstacle_filter_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polar_bin_obstacle_filter_test
// Self-checking bench for the polar bin filter: a queue of add, read and
// register items feeds a handshake driver, a bit-exact bin model predicts each
// read, and a monitor compares every result strobe against it.
// ----------------------------------------------------------------------------
module polar_bin_obstacle_filter_test;
	import pbof_pkg::*;

	typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_t;

	typedef struct {
		op_t         op;
		logic        cmd;
		logic [15:0] x, y, z;
		logic [10:0] bin;
		cfg_reg_t    idx;
		logic [15:0] data;
	} pending_t;

	typedef struct {
		logic [15:0] x, y, z;
		kind_t       kind;
	} scan_pt_t;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam int   SETTLE   = 30;

	logic        clk = 1'b0, arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        start = 1'b0, command = 1'b0;
	logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
	logic [10:0] bin_index = '0;
	logic        busy, done;
	logic signed [15:0] out_x, out_y, out_z;
	logic [1:0]  point_kind;

	polar_bin_obstacle_filter u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .command(command),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.bin_index(bin_index), .done(done), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .point_kind(point_kind)
	);

	int atan_tbl [CORDIC_STEPS] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
		1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

	// model state and registers
	logic [11:0]        m_rmin, m_rmax;
	logic signed [15:0] m_glow, m_split, m_ohigh, m_off;
	logic [1:0]         bin_flags [BINS];
	logic [23:0]        gnd_rsq [BINS], obst_rsq [BINS];
	point_t             gnd_pt [BINS], obst_pt [BINS];

	// generator's view of the offset, to aim reads at clusters
	int gen_off = 714;

	pending_t pend_q[$];
	scan_pt_t scan_q[$];
	int  errors = 0;
	bit  took = 1'b0;
	bit  calm = 1'b0;
	int  gap = 0, settle = 0;

	initial forever #1 clk = ~clk;

	function automatic logic [10:0] bearing_bin(int x, int y, int off);
		longint cx, cy, dx, dy, b;
		logic [ANG_W-1:0] a, t;
		cx = longint'(x) * 2560;
		cy = (longint'(y) * 10 - off) * 256;
		a = '0;
		if (cx < 0) begin
			cx = -cx;
			cy = -cy;
			a = HALF_TURN;
		end
		if (cx != 0 || cy != 0) begin
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					a = a + ANG_W'(atan_tbl[i]);
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					a = a - ANG_W'(atan_tbl[i]);
				end
			end
		end
		t = THREE_QUART - a;
		b = (longint'(t) * TURN_BINS) >> ANG_W;
		if (b > BINS - 1)
			b = BINS - 1;
		return b[10:0];
	endfunction

	task automatic reset_model();
		m_rmin = 12'd20; m_rmax = 12'd2000;
		m_glow = -16'sd50; m_split = 16'sd30; m_ohigh = 16'sd180; m_off = 16'sd714;
		for (int b = 0; b < BINS; b++) begin
			bin_flags[b] = '0;
			gnd_rsq[b] = '0; obst_rsq[b] = '0;
			gnd_pt[b] = '0; obst_pt[b] = '0;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		case (cfg_reg_t'(idx))
			REG_RANGE_MIN:  m_rmin = d[11:0];
			REG_RANGE_MAX:  m_rmax = d[11:0];
			REG_GROUND_LOW: m_glow = d;
			REG_BAND_SPLIT: m_split = d;
			REG_OBST_HIGH:  m_ohigh = d;
			REG_Y_OFFSET:   m_off = d;
			default: ;
		endcase
	endtask

	task automatic bin_update(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [10:0] idx);
		longint   r2;
		int       b;
		scan_pt_t r;
		point_t   p;
		r = '{x: '0, y: '0, z: '0, kind: KIND_NONE};
		p = '{x: x, y: y, z: z};
		if (cmd == CMD_ADD) begin
			b = bearing_bin(x, y, m_off);
			r2 = longint'(x) * x + longint'(y) * y;
			if (r2 < longint'(m_rmin) * m_rmin || r2 > longint'(m_rmax) * m_rmax)
				return;
			if (z > m_glow && z < m_split) begin
				if (!bin_flags[b][0] || r2 > gnd_rsq[b]) begin
					bin_flags[b][0] = 1'b1;
					gnd_rsq[b] = r2[23:0];
					gnd_pt[b] = p;
				end
			end else if (z >= m_split && z < m_ohigh) begin
				if (!bin_flags[b][1] || r2 < obst_rsq[b]) begin
					bin_flags[b][1] = 1'b1;
					obst_rsq[b] = r2[23:0];
					obst_pt[b] = p;
				end
			end
		end else begin
			b = idx;
			if (b < BINS) begin
				if (bin_flags[b] == 2'b01)
					r.kind = KIND_GROUND;
				else if (bin_flags[b] == 2'b10)
					r.kind = KIND_OBSTACLE;
				else if (bin_flags[b] == 2'b11)
					r.kind = (gnd_rsq[b] < obst_rsq[b]) ? KIND_GROUND : KIND_OBSTACLE;
				if (r.kind == KIND_GROUND) begin
					r.x = gnd_pt[b].x; r.y = gnd_pt[b].y; r.z = gnd_pt[b].z;
				end else if (r.kind == KIND_OBSTACLE) begin
					r.x = obst_pt[b].x; r.y = obst_pt[b].y; r.z = obst_pt[b].z;
				end
				bin_flags[b] = '0;
				gnd_rsq[b] = '0; obst_rsq[b] = '0;
				gnd_pt[b] = '0; obst_pt[b] = '0;
			end
			scan_q = {scan_q, r};
		end
	endtask

	// stimulus queue helpers
	task automatic enqueue(pending_t it);
		pend_q = {pend_q, it};
	endtask

	task automatic push_add(int x, int y, int z);
		enqueue('{op: OP_ITEM, cmd: CMD_ADD, x: x[15:0], y: y[15:0], z: z[15:0],
			bin: 11'($urandom), idx: REG_RANGE_MIN, data: 16'($urandom)});
	endtask

	task automatic push_read(int b);
		enqueue('{op: OP_ITEM, cmd: CMD_READ, x: 16'($urandom), y: 16'($urandom),
			z: 16'($urandom), bin: b[10:0], idx: REG_RANGE_MIN, data: '0});
	endtask

	task automatic push_drain();
		enqueue('{op: OP_DRAIN, cmd: CMD_ADD, x: '0, y: '0, z: '0, bin: '0,
			idx: REG_RANGE_MIN, data: '0});
	endtask

	task automatic push_cfg(cfg_reg_t idx, int d);
		if (idx == REG_Y_OFFSET)
			gen_off = int'($signed(d[15:0]));
		enqueue('{op: OP_CFG, cmd: CMD_ADD, x: '0, y: '0, z: '0, bin: '0,
			idx: idx, data: d[15:0]});
	endtask

	// driver: one nonblocking write per signal per falling edge
	always @(negedge clk) begin
		logic     n_start, n_we;
		pending_t it;
		n_start = start;
		n_we = 1'b0;
		if (arst_n) begin
			if (start && took) begin
				n_start = 1'b0;
				took = 1'b0;
				if ($urandom_range(0, 79) == 0)
					calm = !calm;
				gap = calm ? 0 : $urandom_range(0, 13);
			end
			if (!n_start) begin
				if (gap > 0) begin
					gap--;
				end else if (pend_q.size() != 0) begin
					case (pend_q[0].op)
						OP_ITEM: begin
							it = pend_q.pop_front();
							command <= it.cmd;
							point_x <= it.x; point_y <= it.y; point_z <= it.z;
							bin_index <= it.bin;
							n_start = 1'b1;
						end
						OP_CFG: begin
							// registers change only with no item in flight
							if (!busy) begin
								it = pend_q.pop_front();
								cfg_index <= it.idx;
								cfg_data <= it.data;
								n_we = 1'b1;
							end
						end
						default: begin
							// wait for the block to go quiet, then let it settle
							if (scan_q.size() == 0 && !busy) begin
								settle++;
								if (settle >= SETTLE) begin
									settle = 0;
									void'(pend_q.pop_front());
								end
							end else begin
								settle = 0;
							end
						end
					endcase
				end
			end
		end
		start <= n_start;
		cfg_we <= n_we;
	end

	// monitor and predictor
	always @(posedge clk) begin
		scan_pt_t e;
		if (arst_n) begin
			if (done) begin
				if (scan_q.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d z=%0d kind=%0d", $time,
						out_x, out_y, out_z, point_kind);
					errors++;
				end else begin
					e = scan_q.pop_front();
					if (out_x !== e.x || out_y !== e.y || out_z !== e.z
							|| point_kind !== e.kind) begin
						$display("%0t: mismatch expected x=%0d y=%0d z=%0d kind=%0d, got x=%0d y=%0d z=%0d kind=%0d",
							$time, $signed(e.x), $signed(e.y), $signed(e.z), e.kind,
							out_x, out_y, out_z, point_kind);
						errors++;
					end
				end
			end
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (start && !busy) begin
				took = 1'b1;
				bin_update(command, point_x, point_y, point_z, bin_index);
			end
		end
	end

	// random cluster around a base point, then a read of its bin; sometimes noise
	task automatic random_phase(int n, int reach);
		int bx, by, k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			if (k == 0) begin
				push_add(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
					int'($signed(16'($urandom))));
			end else if (k == 1) begin
				push_read($urandom_range(0, 2047));
			end else begin
				bx = int'($urandom_range(0, 2 * reach)) - reach;
				by = int'($urandom_range(0, 2 * reach)) - reach;
				for (int j = $urandom_range(1, 5); j > 0; j--) begin
					if ($urandom_range(0, 3) == 0)
						push_add(bx, by, $urandom_range(0, 260) - 80);
					else
						push_add(bx + $urandom_range(0, 4) - 2, by + $urandom_range(0, 4) - 2,
							$urandom_range(0, 260) - 80);
					i++;
				end
				push_read(bearing_bin(bx, by, gen_off));
			end
		end
		push_drain();
	endtask

	initial begin
		reset_model();
		// directed: empty and out-of-range reads
		push_read(0); push_read(BINS - 1); push_read(BINS); push_read(2047);
		// ground and obstacle points at different bearings; the ground point's bin reads ground
		push_add(100, 0, 0); push_add(300, 0, 100); push_read(bearing_bin(100, 0, 714));
		// tie between bands goes to the obstacle
		push_add(200, 0, 0); push_add(200, 0, 50); push_read(bearing_bin(200, 0, 714));
		// equal ground range does not replace
		push_add(300, 10, -10); push_add(300, 10, 5); push_read(bearing_bin(300, 10, 714));
		// range window edges and band edges
		push_add(2000, 0, 100); push_read(bearing_bin(2000, 0, 714));
		push_add(2001, 0, 100); push_add(0, -20, -49); push_read(bearing_bin(0, -20, 714));
		push_add(0, -19, 30); push_add(0, 500, -50); push_add(0, 500, 180);
		push_read(bearing_bin(0, 500, 714));
		push_add(32767, -32768, 32767); push_add(-32768, 32767, -32768);
		push_add(-700, -700, 30); push_read(bearing_bin(-700, -700, 714));
		push_drain();
		random_phase(260, 1500);
		// extremes, zero vector
		push_cfg(REG_RANGE_MIN, 0); push_cfg(REG_RANGE_MAX, 4095);
		push_cfg(REG_GROUND_LOW, -32768); push_cfg(REG_BAND_SPLIT, 0);
		push_cfg(REG_OBST_HIGH, 32767); push_cfg(REG_Y_OFFSET, 0);
		push_add(0, 0, 5); push_read(1350);
		random_phase(260, 3000);
		push_cfg(REG_Y_OFFSET, -32768); push_cfg(REG_RANGE_MIN, 16'hFFFF);
		push_cfg(REG_OBST_HIGH, 200); push_cfg(REG_GROUND_LOW, 16'h7FFF);
		random_phase(200, 4000);
		// inverted window and empty bands
		push_cfg(REG_RANGE_MIN, 800); push_cfg(REG_RANGE_MAX, 700);
		push_cfg(REG_Y_OFFSET, 32767);
		random_phase(120, 1000);
		push_cfg(REG_RANGE_MIN, 10); push_cfg(REG_RANGE_MAX, 2500);
		push_cfg(REG_GROUND_LOW, 40); push_cfg(REG_BAND_SPLIT, 40); push_cfg(REG_OBST_HIGH, 20);
		random_phase(200, 2000);
		push_cfg(REG_RANGE_MIN, 20); push_cfg(REG_RANGE_MAX, 2000);
		push_cfg(REG_GROUND_LOW, -50); push_cfg(REG_BAND_SPLIT, 30);
		push_cfg(REG_OBST_HIGH, 180); push_cfg(REG_Y_OFFSET, 714);
		random_phase(540, 1500);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pend_q.size() != 0 || start || scan_q.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
